// ===== rtl/lsjm_pkg.sv =====
// lsjm_pkg: shared types and constants for the link session loss and jitter monitor
// used by lsjm_session and link_session_loss_jitter_monitor_core; no dependencies
`timescale 1ns / 1ps

package lsjm_pkg;

  // header sync bytes and the handle value that means not connected
  localparam logic [7:0]  HDR_SYNC0   = 8'hAA;
  localparam logic [7:0]  HDR_SYNC1   = 8'h55;
  localparam logic [15:0] HANDLE_NONE = 16'hFFFF;
  localparam logic [15:0] TARGET_RST  = 16'd1000;
  localparam logic [15:0] HDR_MIN_LEN = 16'd4;

  // saturation limits
  localparam int          JIT_W     = 48;
  localparam logic [15:0] CNT16_MAX = 16'hFFFF;
  localparam logic [31:0] CNT32_MAX = 32'hFFFF_FFFF;
  localparam logic [JIT_W-1:0] JIT_MAX = 48'hFFFF_FFFF_FFFF;

  // configuration register indexes
  localparam logic [1:0] CFG_HANDLE_ONE = 2'd0;
  localparam logic [1:0] CFG_HANDLE_TWO = 2'd1;
  localparam logic [1:0] CFG_TARGET     = 2'd2;

  // matched node codes
  localparam logic [1:0] NODE_NONE = 2'd0;
  localparam logic [1:0] NODE_ONE  = 2'd1;
  localparam logic [1:0] NODE_TWO  = 2'd2;

  // per-packet fields a session update needs besides the timestamp
  typedef struct packed {
    logic [15:0] len;
    logic [15:0] seq;
  } event_t;

  // statistics of a session that this packet completed
  typedef struct packed {
    logic             done;
    logic [15:0]      pkt_count;
    logic [31:0]      lost;
    logic [31:0]      bytes;
    logic [JIT_W-1:0] jitter_sum;
  } report_t;

endpackage

// ===== rtl/lsjm_session.sv =====
// lsjm_session: state and combinational update logic of one monitored session
// depends on lsjm_pkg (event_t, report_t, saturation limits)
`timescale 1ns / 1ps

module lsjm_session #(
  parameter int TIME_BITS = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   upd,
  input  lsjm_pkg::event_t       evt,
  input  logic [TIME_BITS-1:0]   now,
  input  logic [15:0]            target,
  output lsjm_pkg::report_t      rep,
  output logic [TIME_BITS-1:0]   rep_start
);
  import lsjm_pkg::*;

  localparam int SUM_W = ((TIME_BITS > JIT_W) ? TIME_BITS : JIT_W) + 1;

  logic [15:0]          pkt_count;
  logic [31:0]          lost;
  logic [31:0]          bytes;
  logic [JIT_W-1:0]     jitter_sum;
  logic [TIME_BITS-1:0] start_time;
  logic [TIME_BITS-1:0] last_arrival;
  logic [15:0]          prev_seq;

  logic [TIME_BITS-1:0] start_eff;
  logic [TIME_BITS-1:0] diff;
  logic [SUM_W-1:0]     jit_sum;
  logic [JIT_W-1:0]     jitter_sum_next;
  logic [16:0]          seq_ext;
  logic [16:0]          expect_seq;
  logic [16:0]          gap;
  logic [32:0]          lost_sum;
  logic [31:0]          lost_next;
  logic [15:0]          pkt_count_next;
  logic [32:0]          bytes_sum;
  logic [31:0]          bytes_next;
  logic                 done;

  always_comb begin
    // a session with no packets and a zero start time takes this packet's time as its start
    start_eff = (pkt_count == '0 && start_time == '0) ? now : start_time;

    diff    = (now >= last_arrival) ? now - last_arrival : last_arrival - now;
    jit_sum = SUM_W'(jitter_sum) + SUM_W'(diff);
    if (last_arrival != '0) begin
      jitter_sum_next = (jit_sum > SUM_W'(JIT_MAX)) ? JIT_MAX : jit_sum[JIT_W-1:0];
    end else begin
      jitter_sum_next = jitter_sum;
    end

    seq_ext    = {1'b0, evt.seq};
    expect_seq = {1'b0, prev_seq} + 17'd1;
    gap        = seq_ext - expect_seq;
    lost_sum   = {1'b0, lost} + {17'd0, gap[15:0]};
    if (pkt_count != '0 && seq_ext > expect_seq) begin
      lost_next = lost_sum[32] ? CNT32_MAX : lost_sum[31:0];
    end else begin
      lost_next = lost;
    end

    pkt_count_next = (pkt_count != CNT16_MAX) ? pkt_count + 16'd1 : pkt_count;
    bytes_sum      = {1'b0, bytes} + {17'd0, evt.len};
    bytes_next     = bytes_sum[32] ? CNT32_MAX : bytes_sum[31:0];

    done = (pkt_count_next >= target);

    rep.done       = done;
    rep.pkt_count  = pkt_count_next;
    rep.lost       = lost_next;
    rep.bytes      = bytes_next;
    rep.jitter_sum = jitter_sum_next;
    rep_start      = start_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_count    <= '0;
      lost         <= '0;
      bytes        <= '0;
      jitter_sum   <= '0;
      start_time   <= '0;
      last_arrival <= '0;
      prev_seq     <= '0;
    end else if (upd) begin
      if (done) begin
        // restart with this packet's time as the new start
        pkt_count    <= '0;
        lost         <= '0;
        bytes        <= '0;
        jitter_sum   <= '0;
        start_time   <= now;
        last_arrival <= '0;
        prev_seq     <= '0;
      end else begin
        pkt_count    <= pkt_count_next;
        lost         <= lost_next;
        bytes        <= bytes_next;
        jitter_sum   <= jitter_sum_next;
        start_time   <= start_eff;
        last_arrival <= now;
        prev_seq     <= evt.seq;
      end
    end
  end

endmodule

// ===== rtl/link_session_loss_jitter_monitor_core.sv =====
// link_session_loss_jitter_monitor_core: top level of the session loss and jitter monitor
// depends on lsjm_pkg and lsjm_session
`timescale 1ns / 1ps

// Usage
// - input channel (in_valid / in_stall) carries one received-notification event per
//   transfer: handle, arrival time, length and the first four payload bytes
// - output channel (out_valid / out_stall) carries exactly one result per event:
//   matched session, sequence number, a done pulse with the finished session's
//   statistics, and the running notification count
// - configuration: cfg_we writes cfg_data into register cfg_index (0 handle one,
//   1 handle two, 2 target packet count); index 3 is ignored; write only while idle
// - flow: an accepted event is held in the input register, then the update step writes
//   its result into the output register; one event per cycle is sustained while out_stall
//   is low, set by the single update step that reads and writes the session registers
// - the block has an input register and an output register, so a new event is taken
//   while a finished result still waits on a stalled receiver; in_stall rises only
//   when both registers are full and out_stall is high
// - reset (rst, synchronous) clears both sessions and the notification count, sets
//   both handles to not connected and the target to 1000 packets
module link_session_loss_jitter_monitor_core #(
  parameter int NUM_SESSIONS = 2,
  parameter int TIME_BITS    = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  // event input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [15:0]          link_handle,
  input  logic [TIME_BITS-1:0] arrival_time,
  input  logic [15:0]          packet_length,
  input  logic [7:0]           hdr_byte0,
  input  logic [7:0]           hdr_byte1,
  input  logic [7:0]           hdr_byte2,
  input  logic [7:0]           hdr_byte3,
  // result output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           matched_node,
  output logic [15:0]          seq_number,
  output logic                 session_done,
  output logic [15:0]          report_pkt_count,
  output logic [31:0]          report_lost,
  output logic [31:0]          report_bytes,
  output logic [47:0]          report_jitter_sum,
  output logic [TIME_BITS-1:0] report_start_time,
  output logic [TIME_BITS-1:0] report_end_time,
  output logic [31:0]          notify_total
);
  import lsjm_pkg::*;

  // configuration registers
  logic [15:0] handle_one;
  logic [15:0] handle_two;
  logic [15:0] target;

  // input register stage
  logic                 ev_valid;
  logic [15:0]          ev_handle;
  logic [TIME_BITS-1:0] ev_time;
  logic [15:0]          ev_len;
  logic [7:0]           ev_b0;
  logic [7:0]           ev_b1;
  logic [7:0]           ev_b2;
  logic [7:0]           ev_b3;

  logic [31:0] notify_count;

  logic                    adv;
  logic                    match_one;
  logic                    match_two;
  logic [NUM_SESSIONS-1:0] hit;
  logic [15:0]             seq;
  event_t                  evt;
  report_t                 rep [NUM_SESSIONS];
  logic [TIME_BITS-1:0]    rep_start [NUM_SESSIONS];
  report_t                 rep_sel;
  logic [TIME_BITS-1:0]    start_sel;
  logic                    any_hit;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      handle_one <= HANDLE_NONE;
      handle_two <= HANDLE_NONE;
      target     <= TARGET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HANDLE_ONE: handle_one <= cfg_data;
        CFG_HANDLE_TWO: handle_two <= cfg_data;
        CFG_TARGET:     target     <= cfg_data;
        default: ;
      endcase
    end
  end

  // the update step fires when the output register is free or being drained
  assign adv      = ev_valid && (!out_valid || !out_stall);
  assign in_stall = ev_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (!in_stall) begin
      ev_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ev_handle <= link_handle;
      ev_time   <= arrival_time;
      ev_len    <= packet_length;
      ev_b0     <= hdr_byte0;
      ev_b1     <= hdr_byte1;
      ev_b2     <= hdr_byte2;
      ev_b3     <= hdr_byte3;
    end
  end

  // session match: a not-connected handle never matches, first session wins a tie
  always_comb begin
    match_one = (ev_handle != HANDLE_NONE) && (ev_handle == handle_one);
    match_two = (ev_handle != HANDLE_NONE) && (ev_handle == handle_two) && !match_one
                && (NUM_SESSIONS > 1);
    for (int s = 0; s < NUM_SESSIONS; s++) begin
      hit[s] = (s == 0) ? match_one : ((s == 1) ? match_two : 1'b0);
    end
    any_hit = |hit;
  end

  // sequence number only from a full header with both sync bytes
  always_comb begin
    if (ev_len >= HDR_MIN_LEN && ev_b0 == HDR_SYNC0 && ev_b1 == HDR_SYNC1) begin
      seq = {ev_b3, ev_b2};
    end else begin
      seq = '0;
    end
    evt.len = ev_len;
    evt.seq = seq;
  end

  // one state slot per session
  for (genvar s = 0; s < NUM_SESSIONS; s++) begin : g_sess
    lsjm_session #(
      .TIME_BITS(TIME_BITS)
    ) u_sess (
      .clk       (clk),
      .rst       (rst),
      .upd       (adv && hit[s]),
      .evt       (evt),
      .now       (ev_time),
      .target    (target),
      .rep       (rep[s]),
      .rep_start (rep_start[s])
    );
  end

  // pick the matched slot's report
  always_comb begin
    rep_sel   = '0;
    start_sel = '0;
    for (int s = 0; s < NUM_SESSIONS; s++) begin
      if (hit[s]) begin
        rep_sel   = rep[s];
        start_sel = rep_start[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      notify_count <= '0;
    end else if (adv) begin
      notify_count <= notify_count + 32'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      notify_total <= notify_count + 32'd1;
      if (match_one) begin
        matched_node <= NODE_ONE;
      end else if (match_two) begin
        matched_node <= NODE_TWO;
      end else begin
        matched_node <= NODE_NONE;
      end
      seq_number <= any_hit ? seq : '0;
      // report fields stay zero unless this packet closed its session
      if (any_hit && rep_sel.done) begin
        session_done      <= 1'b1;
        report_pkt_count  <= rep_sel.pkt_count;
        report_lost       <= rep_sel.lost;
        report_bytes      <= rep_sel.bytes;
        report_jitter_sum <= rep_sel.jitter_sum;
        report_start_time <= start_sel;
        report_end_time   <= ev_time;
      end else begin
        session_done      <= 1'b0;
        report_pkt_count  <= '0;
        report_lost       <= '0;
        report_bytes      <= '0;
        report_jitter_sum <= '0;
        report_start_time <= '0;
        report_end_time   <= '0;
      end
    end
  end

endmodule

// ===== tb/sv/tb_link_session_loss_jitter_monitor_core.sv =====
// tb_link_session_loss_jitter_monitor_core: self-checking bench for the loss/jitter monitor
// drives notification transfers, predicts every result in-bench and checks them in order
// depends on lsjm_pkg and link_session_loss_jitter_monitor_core
`timescale 1ns / 1ps

module tb_link_session_loss_jitter_monitor_core;
  import lsjm_pkg::*;

  // unused register slot, writes there must be dropped by the block
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 68;

  // one received notification as it goes on the input channel
  typedef struct packed {
    logic [15:0] handle;
    logic [47:0] atime;
    logic [15:0] len;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
  } notif_t;

  // one result transfer as it leaves the output channel
  typedef struct packed {
    logic [1:0]  node;
    logic [15:0] seq;
    logic        done;
    logic [15:0] rx;
    logic [31:0] lost;
    logic [31:0] bytes;
    logic [47:0] jit;
    logic [47:0] t_start;
    logic [47:0] t_end;
    logic [31:0] total;
  } stats_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  // block inputs, all known from time zero
  logic        cfg_we        = 1'b0;
  logic [1:0]  cfg_index     = CFG_HANDLE_ONE;
  logic [15:0] cfg_data      = '0;
  logic        in_valid      = 1'b0;
  logic [15:0] link_handle   = '0;
  logic [47:0] arrival_time  = '0;
  logic [15:0] packet_length = '0;
  logic [7:0]  hdr_byte0     = '0;
  logic [7:0]  hdr_byte1     = '0;
  logic [7:0]  hdr_byte2     = '0;
  logic [7:0]  hdr_byte3     = '0;
  logic        out_stall     = 1'b0;

  // block outputs
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  matched_node;
  logic [15:0] seq_number;
  logic        session_done;
  logic [15:0] report_pkt_count;
  logic [31:0] report_lost;
  logic [31:0] report_bytes;
  logic [47:0] report_jitter_sum;
  logic [47:0] report_start_time;
  logic [47:0] report_end_time;
  logic [31:0] notify_total;

  link_session_loss_jitter_monitor_core DUT (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .link_handle       (link_handle),
    .arrival_time      (arrival_time),
    .packet_length     (packet_length),
    .hdr_byte0         (hdr_byte0),
    .hdr_byte1         (hdr_byte1),
    .hdr_byte2         (hdr_byte2),
    .hdr_byte3         (hdr_byte3),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .matched_node      (matched_node),
    .seq_number        (seq_number),
    .session_done      (session_done),
    .report_pkt_count  (report_pkt_count),
    .report_lost       (report_lost),
    .report_bytes      (report_bytes),
    .report_jitter_sum (report_jitter_sum),
    .report_start_time (report_start_time),
    .report_end_time   (report_end_time),
    .notify_total      (notify_total)
  );

  // ---------------------------------------------------------------------------
  // session predictor: own copy of config and per-session statistics
  // ---------------------------------------------------------------------------
  logic [15:0] handle_one = HANDLE_NONE;
  logic [15:0] handle_two = HANDLE_NONE;
  logic [15:0] target_pk  = TARGET_RST;

  logic [15:0] pk_count [2];
  logic [31:0] pk_lost  [2];
  logic [31:0] pk_bytes [2];
  logic [47:0] jit_acc  [2];
  logic [47:0] t_open   [2];
  logic [47:0] t_prev   [2];
  logic [15:0] seq_prev [2];
  logic [31:0] notif_count = '0;

  function automatic void clear_lane(int unsigned k);
    pk_count[k] = '0;
    pk_lost[k]  = '0;
    pk_bytes[k] = '0;
    jit_acc[k]  = '0;
    t_open[k]   = '0;
    t_prev[k]   = '0;
    seq_prev[k] = '0;
  endfunction

  initial begin
    clear_lane(0);
    clear_lane(1);
  end

  // advance the session state by one notification and return the result it produces
  function automatic stats_t session_update(notif_t n);
    stats_t      r;
    int unsigned k;
    logic [15:0] seq;
    logic [47:0] dt;
    logic [48:0] sum49;
    logic [32:0] sum33;
    logic [15:0] gap;
    r = '0;
    notif_count = notif_count + 32'd1;   // wraps
    r.total = notif_count;
    // a register at the not-connected value never matches; first session wins a tie
    if (n.handle != HANDLE_NONE && n.handle == handle_one) r.node = NODE_ONE;
    else if (n.handle != HANDLE_NONE && n.handle == handle_two) r.node = NODE_TWO;
    if (r.node == NODE_NONE) return r;
    k = (r.node == NODE_ONE) ? 0 : 1;

    // short or bad header leaves the sequence number at zero
    seq = '0;
    if (n.len >= HDR_MIN_LEN && n.b0 == HDR_SYNC0 && n.b1 == HDR_SYNC1) seq = {n.b3, n.b2};

    // fresh session takes this arrival as its start
    if (pk_count[k] == '0 && t_open[k] == '0) begin
      clear_lane(k);
      t_open[k] = n.atime;
    end

    // no jitter while the previous arrival is still zero
    if (t_prev[k] != '0) begin
      dt = (n.atime >= t_prev[k]) ? n.atime - t_prev[k] : t_prev[k] - n.atime;
      sum49 = {1'b0, jit_acc[k]} + {1'b0, dt};
      jit_acc[k] = sum49[48] ? JIT_MAX : sum49[47:0];
    end
    t_prev[k] = n.atime;

    // only forward gaps count as loss
    if (pk_count[k] != '0 && {1'b0, seq} > {1'b0, seq_prev[k]} + 17'd1) begin
      gap = seq - seq_prev[k] - 16'd1;
      sum33 = {1'b0, pk_lost[k]} + {17'b0, gap};
      pk_lost[k] = sum33[32] ? CNT32_MAX : sum33[31:0];
    end
    seq_prev[k] = seq;

    if (pk_count[k] < CNT16_MAX) pk_count[k] = pk_count[k] + 16'd1;
    sum33 = {1'b0, pk_bytes[k]} + {17'b0, n.len};
    pk_bytes[k] = sum33[32] ? CNT32_MAX : sum33[31:0];

    r.seq = seq;
    // target reached: report, then restart with this arrival as the new start
    if (pk_count[k] >= target_pk) begin
      r.done    = 1'b1;
      r.rx      = pk_count[k];
      r.lost    = pk_lost[k];
      r.bytes   = pk_bytes[k];
      r.jit     = jit_acc[k];
      r.t_start = t_open[k];
      r.t_end   = n.atime;
      clear_lane(k);
      t_open[k] = n.atime;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // shared bench state
  // ---------------------------------------------------------------------------
  notif_t notif_backlog [$];      // notifications waiting to be offered
  stats_t expected_reports [$];   // predicted results, oldest first
  int unsigned mismatches = 0;

  bit in_gaps_on   = 1'b1;
  bit out_gaps_on  = 1'b1;
  bit hold_pending = 1'b0;
  int unsigned hold_left = 0;

  // mostly short idles, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers the backlog on the input channel, predicts on each transfer
  // ---------------------------------------------------------------------------
  notif_t      offered;
  int unsigned send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!(in_valid && in_stall)) begin
      // a stalled payload stays put; otherwise the current one has transferred (if any)
      if (in_valid) expected_reports.push_back(session_update(offered));
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (notif_backlog.size() != 0) begin
        offered = notif_backlog.pop_front();
        link_handle   <= offered.handle;
        arrival_time  <= offered.atime;
        packet_length <= offered.len;
        hdr_byte0     <= offered.b0;
        hdr_byte1     <= offered.b1;
        hdr_byte2     <= offered.b2;
        hdr_byte3     <= offered.b3;
        in_valid      <= 1'b1;
        send_gap = in_gaps_on ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // long receiver hold-off, counted here so the block backs up into its input
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_pending) begin
      hold_left <= HOLD_CYCLES;
      hold_pending = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks every result transfer and drives the receiver stall
  // ---------------------------------------------------------------------------
  task automatic field_check(string what, logic [47:0] want_v, logic [47:0] seen_v);
    if (want_v !== seen_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch %s: expected %0h got %0h", $realtime, what, want_v, seen_v);
    end
  endtask

  stats_t      want;
  int unsigned recv_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t result transfer with nothing expected, notify_total %0h",
                     $realtime, notify_total);
        end else begin
          want = expected_reports.pop_front();
          field_check("matched_node", want.node, matched_node);
          field_check("seq_number", want.seq, seq_number);
          field_check("session_done", want.done, session_done);
          field_check("report_pkt_count", want.rx, report_pkt_count);
          field_check("report_lost", want.lost, report_lost);
          field_check("report_bytes", want.bytes, report_bytes);
          field_check("report_jitter_sum", want.jit, report_jitter_sum);
          field_check("report_start_time", want.t_start, report_start_time);
          field_check("report_end_time", want.t_end, report_end_time);
          field_check("notify_total", want.total, notify_total);
        end
      end
      // stall for next cycle: long hold first, then random gaps
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        recv_gap = out_gaps_on ? pick_gap() : 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // register write; the predictor copy follows at once since the block is idle
  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_HANDLE_ONE: handle_one = val;
      CFG_HANDLE_TWO: handle_two = val;
      CFG_TARGET:     target_pk  = val;
      default: ;
    endcase
  endtask

  task automatic cfg_close();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_notif(logic [15:0] h, logic [47:0] t, logic [15:0] len,
                            logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
    notif_t n;
    n = '{handle: h, atime: t, len: len, b0: b0, b1: b1, b2: b2, b3: b3};
    notif_backlog.push_back(n);
  endtask

  // idle means nothing queued, nothing offered and nothing outstanding
  task automatic wait_idle();
    do @(negedge clk);
    while (notif_backlog.size() != 0 || in_valid || expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // per-lane arrival clock and sequence so most traffic forms real sessions
  logic [47:0] lane_time [2] = '{48'd0, 48'd0};
  logic [15:0] lane_seq  [2] = '{16'd0, 16'd0};

  // lane 0 / 1 aim at the configured sessions, lane 2 is stray traffic
  function automatic notif_t make_notif(int unsigned lane);
    notif_t      n;
    int unsigned r;
    logic [15:0] s;
    n.handle = (lane == 0) ? handle_one : (lane == 1) ? handle_two : 16'($urandom);

    r = $urandom_range(0, 99);
    if (lane < 2 && r < 85) begin
      lane_time[lane] = lane_time[lane] + 48'($urandom_range(1, 5000));
      n.atime = lane_time[lane];
    end else begin
      n.atime = 48'({$urandom, $urandom});
      if (lane < 2) lane_time[lane] = n.atime;
    end

    r = $urandom_range(0, 99);
    if (r < 70) n.len = 16'($urandom_range(4, 256));
    else if (r < 87) n.len = 16'($urandom);
    else n.len = 16'($urandom_range(0, 3));

    r = $urandom_range(0, 99);
    if (lane < 2) begin
      if (r < 60) s = lane_seq[lane] + 16'd1;
      else if (r < 75) s = lane_seq[lane] + 16'($urandom_range(2, 40));
      else if (r < 85) s = lane_seq[lane] - 16'($urandom_range(0, 5));
      else s = 16'($urandom);
      lane_seq[lane] = s;
    end else begin
      s = 16'($urandom);
    end
    n.b2 = s[7:0];
    n.b3 = s[15:8];

    // mostly a good header, otherwise broken sync bytes
    r = $urandom_range(0, 99);
    if (r < 85) begin
      n.b0 = HDR_SYNC0;
      n.b1 = HDR_SYNC1;
    end else if (r < 92) begin
      n.b0 = HDR_SYNC0;
      n.b1 = 8'($urandom);
    end else begin
      n.b0 = 8'($urandom);
      n.b1 = 8'($urandom);
    end
    return n;
  endfunction

  task automatic random_setup();
    logic [15:0] h1;
    logic [15:0] h2;
    logic [15:0] tgt;
    int unsigned r;
    h1 = ($urandom_range(0, 9) == 0) ? HANDLE_NONE : 16'($urandom);
    r = $urandom_range(0, 9);
    h2 = (r == 0) ? HANDLE_NONE : (r == 1) ? h1 : 16'($urandom);
    r = $urandom_range(0, 19);
    if (r < 2) tgt = 16'd1;
    else if (r < 3) tgt = CNT16_MAX;
    else if (r < 4) tgt = 16'd0;
    else if (r < 12) tgt = 16'($urandom_range(2, 6));
    else tgt = 16'($urandom_range(7, 30));
    cfg_write(CFG_TARGET, tgt);
    cfg_write(CFG_HANDLE_ONE, h1);
    cfg_write(CFG_HANDLE_TWO, h2);
    cfg_close();
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned r;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset config: both handles not connected, so nothing matches
    push_notif(HANDLE_NONE, 48'd10, 16'd8, HDR_SYNC0, HDR_SYNC1, 8'h01, 8'h00);
    push_notif(16'h0000, 48'd20, 16'd8, HDR_SYNC0, HDR_SYNC1, 8'h02, 8'h00);
    wait_idle();

    // session one on handle 0, session two on 0xfffe, three packets per session
    cfg_write(CFG_HANDLE_ONE, 16'h0000);
    cfg_write(CFG_HANDLE_TWO, 16'hFFFE);
    cfg_write(CFG_TARGET, 16'd3);
    cfg_close();
    @(negedge clk);
    // start at time zero with an empty payload
    push_notif(16'h0000, 48'd0, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    // previous arrival still zero, so no jitter; sequence jump gives loss
    push_notif(16'h0000, 48'd100, 16'd4, HDR_SYNC0, HDR_SYNC1, 8'h05, 8'h00);
    // sequence going back, largest time and length, completes the session
    push_notif(16'h0000, 48'hFFFF_FFFF_FFFF, 16'hFFFF, HDR_SYNC0, HDR_SYNC1, 8'h03, 8'h00);
    // short payload hides a good header
    push_notif(16'hFFFE, 48'd1, 16'd3, HDR_SYNC0, HDR_SYNC1, 8'hFF, 8'hFF);
    // bad first sync byte, then bad second one; jitter sum saturates
    push_notif(16'hFFFE, 48'hFFFF_FFFF_FFFF, 16'd16, 8'hAB, HDR_SYNC1, 8'h10, 8'h00);
    push_notif(16'hFFFE, 48'd1, 16'd16, HDR_SYNC0, 8'h54, 8'h11, 8'h00);
    push_notif(16'h1234, 48'd77, 16'd20, HDR_SYNC0, HDR_SYNC1, 8'h12, 8'h34);
    push_notif(HANDLE_NONE, 48'd78, 16'd20, HDR_SYNC0, HDR_SYNC1, 8'h12, 8'h34);
    wait_idle();

    // both handles equal (first wins), target zero, and a write to the unused slot
    cfg_write(CFG_TARGET, 16'd0);
    cfg_write(CFG_HANDLE_ONE, 16'h00A5);
    cfg_write(CFG_HANDLE_TWO, 16'h00A5);
    cfg_write(CFG_UNUSED, 16'hFFFF);
    cfg_close();
    @(negedge clk);
    push_notif(16'h00A5, 48'h8000_0000_0000, 16'd4, HDR_SYNC0, HDR_SYNC1, 8'hFF, 8'hFF);
    push_notif(16'h00A5, 48'h8000_0000_0010, 16'd5, HDR_SYNC0, HDR_SYNC1, 8'h00, 8'h00);
    push_notif(16'h0000, 48'd5, 16'd4, HDR_SYNC0, HDR_SYNC1, 8'h01, 8'h00);
    wait_idle();

    // first register not connected, second handle in use, and the largest target
    cfg_write(CFG_HANDLE_ONE, HANDLE_NONE);
    cfg_write(CFG_HANDLE_TWO, 16'h8001);
    cfg_write(CFG_TARGET, CNT16_MAX);
    cfg_write(CFG_UNUSED, 16'h0000);
    cfg_close();
    @(negedge clk);
    push_notif(HANDLE_NONE, 48'd3, 16'd4, HDR_SYNC0, HDR_SYNC1, 8'h01, 8'h00);
    push_notif(16'h8001, 48'd5, 16'd300, HDR_SYNC0, HDR_SYNC1, 8'h01, 8'h00);
    push_notif(16'h8001, 48'd9, 16'd300, HDR_SYNC0, HDR_SYNC1, 8'h03, 8'h00);
    wait_idle();

    // random phases, each with its own register setting
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      random_setup();
      @(negedge clk);
      // one phase without any idling, one with a long receiver hold-off
      in_gaps_on  = (p != 1) && (p != 3);
      out_gaps_on = (p != 1);
      if (p == 3) hold_pending = 1'b1;
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        notif_backlog.push_back(make_notif((r < 40) ? 0 : (r < 75) ? 1 : 2));
      end
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    mismatches += expected_reports.size();
    if (mismatches == 0) begin
      $display("[link_session_loss_jitter_monitor_core] OK");
    end else begin
      $display("[link_session_loss_jitter_monitor_core] ERROR");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("[link_session_loss_jitter_monitor_core] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lsjm_pkg.sv
rtl/lsjm_session.sv
rtl/link_session_loss_jitter_monitor_core.sv
tb/sv/tb_link_session_loss_jitter_monitor_core.sv
